// File: rtl/lzf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzf_pkg
// Shared types and codes for the LZF stream decompressor.
// ----------------------------------------------------------------------------
package lzf_pkg;

   localparam int unsigned WORD_BITS  = 64;
   localparam int unsigned COUNT_BITS = 4;
   localparam int unsigned CODE_BITS  = 3;

   localparam logic [1:0] PH_CTRL = 2'd0;
   localparam logic [1:0] PH_LIT  = 2'd1;
   localparam logic [1:0] PH_LEN  = 2'd2;
   localparam logic [1:0] PH_OFS  = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TRUNC_LIT = 3'd1;
   localparam logic [2:0] ST_TRUNC_LEN = 3'd2;
   localparam logic [2:0] ST_TRUNC_REF = 3'd3;
   localparam logic [2:0] ST_BAD_REF   = 3'd4;
   localparam logic [2:0] ST_SIZE      = 3'd5;

   localparam logic [7:0] LIT_LIMIT   = 8'd32;
   localparam logic [7:0] OFS_HI_MASK = 8'h1f;
   localparam logic [2:0] LEN_EXT     = 3'd7;
   localparam int unsigned LEN_SHIFT  = 5;
   localparam logic [8:0] LEN_BIAS    = 9'd2;

   typedef struct packed {
      logic                 push;
      logic [7:0]           data;
      logic                 flush;
      logic                 last;
      logic                 stat;
      logic [CODE_BITS-1:0] code;
   } pack_ctrl_type;

   typedef struct packed {
      logic room;
      logic flushed;
      logic stat_sent;
   } pack_stat_type;

endpackage
`default_nettype wire

// File: rtl/lzf_hist_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzf_hist_ram
// History ring: one write and one read port, registered read data, with
// write-to-read forwarding when both hit the same entry in one cycle.
// ----------------------------------------------------------------------------
module lzf_hist_ram #(
   parameter int unsigned DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [7:0]               wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [7:0]               rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_q_ff;
   logic       fwd_ff;
   logic [7:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff     <= mem[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_q_ff;

endmodule
`default_nettype wire

// File: rtl/lzf_out_pack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzf_out_pack
// Byte packer and output register for result words.
// ----------------------------------------------------------------------------
module lzf_out_pack #(
   parameter int unsigned LANES = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire lzf_pkg::pack_ctrl_type               ctrl,
   output lzf_pkg::pack_stat_type                    stat,
   output logic                                      out_valid,
   input  wire logic                                 out_ready,
   output logic      [lzf_pkg::WORD_BITS-1:0]        out_word,
   output logic      [lzf_pkg::COUNT_BITS-1:0]       out_count,
   output logic                                      out_last,
   output logic                                      out_done,
   output logic      [lzf_pkg::CODE_BITS-1:0]        out_code
);

   localparam logic [lzf_pkg::COUNT_BITS-1:0] LANE_CNT = lzf_pkg::COUNT_BITS'(LANES);

   logic [8*LANES-1:0]               pk_data_ff, pk_data_in;
   logic [lzf_pkg::COUNT_BITS-1:0]   pk_cnt_ff, pk_cnt_in;
   logic                             ov_ff, ov_in;
   logic [lzf_pkg::WORD_BITS-1:0]    word_ff, word_in;
   logic [lzf_pkg::COUNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                             last_ff, last_in;
   logic                             done_ff, done_in;
   logic [lzf_pkg::CODE_BITS-1:0]    code_ff, code_in;

   logic                             out_free;
   logic                             pk_full;
   logic                             xfer_mid;
   logic                             push_ok;
   logic                             flushed;
   logic                             stat_sent;
   logic [lzf_pkg::COUNT_BITS-1:0]   lane_idx;
   logic [8*LANES-1:0]               base;

   assign out_free  = !ov_ff || out_ready;
   assign pk_full   = (pk_cnt_ff == LANE_CNT);
   assign xfer_mid  = ctrl.push && pk_full && out_free;
   assign push_ok   = ctrl.push && (!pk_full || out_free);
   assign flushed   = ctrl.flush && out_free;
   assign stat_sent = ctrl.stat && out_free;

   assign stat.room      = !pk_full || out_free;
   assign stat.flushed   = flushed;
   assign stat.stat_sent = stat_sent;

   always_comb begin
      pk_data_in = pk_data_ff;
      pk_cnt_in  = pk_cnt_ff;
      lane_idx   = pk_full ? '0 : pk_cnt_ff;
      base       = (pk_full || (pk_cnt_ff == '0)) ? '0 : pk_data_ff;
      if (flushed) begin
         pk_data_in = '0;
         pk_cnt_in  = '0;
      end else if (push_ok) begin
         pk_data_in = base;
         for (int l = 0; l < LANES; l++) begin
            if (lzf_pkg::COUNT_BITS'(l) == lane_idx) begin
               pk_data_in[8*l +: 8] = ctrl.data;
            end
         end
         pk_cnt_in = lane_idx + lzf_pkg::COUNT_BITS'(1);
      end
   end

   always_comb begin
      word_in = word_ff;
      cnt_in  = cnt_ff;
      last_in = last_ff;
      done_in = done_ff;
      code_in = code_ff;
      ov_in   = out_ready ? 1'b0 : ov_ff;
      if (xfer_mid || flushed) begin
         word_in = lzf_pkg::WORD_BITS'(pk_data_ff);
         cnt_in  = pk_cnt_ff;
         last_in = flushed && ctrl.last;
         done_in = 1'b0;
         code_in = lzf_pkg::ST_OK;
         ov_in   = 1'b1;
      end else if (stat_sent) begin
         word_in = '0;
         cnt_in  = '0;
         last_in = 1'b1;
         done_in = 1'b1;
         code_in = ctrl.code;
         ov_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pk_cnt_ff <= '0;
         ov_ff     <= 1'b0;
      end else begin
         pk_cnt_ff <= pk_cnt_in;
         ov_ff     <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      pk_data_ff <= pk_data_in;
      word_ff    <= word_in;
      cnt_ff     <= cnt_in;
      last_ff    <= last_in;
      done_ff    <= done_in;
      code_ff    <= code_in;
   end

   assign out_valid = ov_ff;
   assign out_word  = word_ff;
   assign out_count = cnt_ff;
   assign out_last  = last_ff;
   assign out_done  = done_ff;
   assign out_code  = code_ff;

endmodule
`default_nettype wire

// File: rtl/lzf_stream_decompressor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzf_stream_decompressor
// LZF token decoder with a history ring memory and packed result words.
// ----------------------------------------------------------------------------
//  port group  dir  payload
//  req_*       in   tdata[7:0] in_byte, tlast end_of_stream
//  rsp_*       out  tdata out_word/byte_count/status, tlast run_last,
//                   tuser stream_done
//  csr_*       in   expected_length write
//
//  Control, length and offset-low bytes are decoded on accept; a literal byte is
//  accepted and then its word is flushed. A back-reference of N bytes moves
//  one byte a cycle through the history RAM port unless the rsp side stalls,
//  then drains the read and flushes. End of stream adds a status word. Reset
//  clears control state only; history needs no clearing pass.
//  A stalled rsp side holds the copy loop once the packer and output
//  register are both full.
// ----------------------------------------------------------------------------
module lzf_stream_decompressor #(
   parameter int unsigned HISTORY_DEPTH = 8192,
   parameter int unsigned OUT_LANES     = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] in_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [71:0] rsp_tdata,    // [63:0] out_word, [67:64] byte_count,
                                          // [70:68] status, [71] zero
   output logic             rsp_tlast,
   output logic             rsp_tuser,    // [0] stream_done
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);

   localparam int unsigned AW = $clog2(HISTORY_DEPTH);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_COPY  = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;
   localparam logic [1:0] S_STAT  = 2'd3;

   logic [1:0]    st_ff, st_in;
   logic [31:0]   produced_ff, produced_in;
   logic [1:0]    phase_ff, phase_in;
   logic [5:0]    lit_left_ff, lit_left_in;
   logic [8:0]    mlen_ff, mlen_in;
   logic [4:0]    mofs_ff, mofs_in;
   logic [2:0]    err_ff, err_in;
   logic [31:0]   expected_ff;
   logic          eos_ff, eos_in;
   logic [8:0]    issue_left_ff, issue_left_in;
   logic [AW-1:0] src_ff, src_in;
   logic          rdv_ff, rdv_in;

   logic          accept;
   logic          lit_wr;
   logic          issue;
   logic          consume;
   logic [12:0]   off;
   logic [2:0]    final_code;
   logic          ram_we;
   logic [7:0]    ram_wdata;
   logic [7:0]    ram_rdata;

   lzf_pkg::pack_ctrl_type pk_ctrl;
   lzf_pkg::pack_stat_type pk_stat;

   logic [lzf_pkg::WORD_BITS-1:0]  o_word;
   logic [lzf_pkg::COUNT_BITS-1:0] o_count;
   logic [lzf_pkg::CODE_BITS-1:0]  o_code;

   assign req_tready = (st_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign off        = {mofs_ff, req_tdata};
   assign consume    = (st_ff == S_COPY) && rdv_ff && pk_stat.room;
   assign issue      = (st_ff == S_COPY) && (issue_left_ff != '0) && (!rdv_ff || consume);

   always_comb begin
      if (err_ff != lzf_pkg::ST_OK) final_code = err_ff;
      else if (phase_ff == lzf_pkg::PH_LIT) final_code = lzf_pkg::ST_TRUNC_LIT;
      else if (phase_ff == lzf_pkg::PH_LEN) final_code = lzf_pkg::ST_TRUNC_LEN;
      else if (phase_ff == lzf_pkg::PH_OFS) final_code = lzf_pkg::ST_TRUNC_REF;
      else if (produced_ff != expected_ff) final_code = lzf_pkg::ST_SIZE;
      else final_code = lzf_pkg::ST_OK;
   end

   always_comb begin
      st_in         = st_ff;
      produced_in   = produced_ff;
      phase_in      = phase_ff;
      lit_left_in   = lit_left_ff;
      mlen_in       = mlen_ff;
      mofs_in       = mofs_ff;
      err_in        = err_ff;
      eos_in        = eos_ff;
      issue_left_in = issue_left_ff;
      src_in        = src_ff;
      rdv_in        = issue ? 1'b1 : (consume ? 1'b0 : rdv_ff);
      lit_wr        = 1'b0;

      unique case (st_ff)
         S_IDLE: begin
            if (accept) begin
               eos_in = req_tlast;
               st_in  = req_tlast ? S_STAT : S_IDLE;
               if (err_ff == lzf_pkg::ST_OK) begin
                  unique case (phase_ff)
                     lzf_pkg::PH_CTRL: begin
                        if (req_tdata < lzf_pkg::LIT_LIMIT) begin
                           lit_left_in = req_tdata[5:0] + 6'd1;
                           phase_in    = lzf_pkg::PH_LIT;
                        end else begin
                           mlen_in  = {6'd0, req_tdata[7:lzf_pkg::LEN_SHIFT]};
                           mofs_in  = req_tdata[4:0] & lzf_pkg::OFS_HI_MASK[4:0];
                           phase_in = (req_tdata[7:lzf_pkg::LEN_SHIFT] == lzf_pkg::LEN_EXT)
                                      ? lzf_pkg::PH_LEN : lzf_pkg::PH_OFS;
                        end
                     end
                     lzf_pkg::PH_LIT: begin
                        lit_wr      = 1'b1;
                        produced_in = produced_ff + 32'd1;
                        lit_left_in = lit_left_ff - 6'd1;
                        if (lit_left_ff == 6'd1) phase_in = lzf_pkg::PH_CTRL;
                        st_in = S_FLUSH;
                     end
                     lzf_pkg::PH_LEN: begin
                        mlen_in  = 9'(lzf_pkg::LEN_EXT) + {1'b0, req_tdata};
                        phase_in = lzf_pkg::PH_OFS;
                     end
                     lzf_pkg::PH_OFS: begin
                        phase_in = lzf_pkg::PH_CTRL;
                        if (produced_ff <= {19'd0, off}) begin
                           err_in = lzf_pkg::ST_BAD_REF;
                        end else begin
                           issue_left_in = mlen_ff + lzf_pkg::LEN_BIAS;
                           src_in        = AW'(produced_ff - {19'd0, off} - 32'd1);
                           st_in         = S_COPY;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         S_COPY: begin
            if (issue) begin
               issue_left_in = issue_left_ff - 9'd1;
               src_in        = src_ff + AW'(1);
            end
            if (consume) produced_in = produced_ff + 32'd1;
            if ((issue_left_ff == '0) && !rdv_ff) st_in = S_FLUSH;
         end
         S_FLUSH: begin
            if (pk_stat.flushed) st_in = eos_ff ? S_STAT : S_IDLE;
         end
         S_STAT: begin
            if (pk_stat.stat_sent) begin
               st_in       = S_IDLE;
               produced_in = '0;
               phase_in    = lzf_pkg::PH_CTRL;
               lit_left_in = '0;
               mlen_in     = '0;
               mofs_in     = '0;
               err_in      = lzf_pkg::ST_OK;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= S_IDLE;
         produced_ff   <= '0;
         phase_ff      <= lzf_pkg::PH_CTRL;
         lit_left_ff   <= '0;
         mlen_ff       <= '0;
         mofs_ff       <= '0;
         err_ff        <= lzf_pkg::ST_OK;
         expected_ff   <= '0;
         eos_ff        <= 1'b0;
         issue_left_ff <= '0;
         rdv_ff        <= 1'b0;
      end else begin
         st_ff         <= st_in;
         produced_ff   <= produced_in;
         phase_ff      <= phase_in;
         lit_left_ff   <= lit_left_in;
         mlen_ff       <= mlen_in;
         mofs_ff       <= mofs_in;
         err_ff        <= err_in;
         eos_ff        <= eos_in;
         issue_left_ff <= issue_left_in;
         rdv_ff        <= rdv_in;
         if (csr_wr_en) expected_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      src_ff <= src_in;
   end

   assign ram_we    = lit_wr || consume;
   assign ram_wdata = lit_wr ? req_tdata : ram_rdata;

   lzf_hist_ram #(
      .DEPTH (HISTORY_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (produced_ff[AW-1:0]),
      .wr_data (ram_wdata),
      .rd_en   (issue),
      .rd_addr (src_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      pk_ctrl.push  = lit_wr || ((st_ff == S_COPY) && rdv_ff);
      pk_ctrl.data  = ram_wdata;
      pk_ctrl.flush = (st_ff == S_FLUSH);
      pk_ctrl.last  = !eos_ff;
      pk_ctrl.stat  = (st_ff == S_STAT);
      pk_ctrl.code  = final_code;
   end

   lzf_out_pack #(
      .LANES (OUT_LANES)
   ) u_pack (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (pk_ctrl),
      .stat      (pk_stat),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (o_word),
      .out_count (o_count),
      .out_last  (rsp_tlast),
      .out_done  (rsp_tuser),
      .out_code  (o_code)
   );

   assign rsp_tdata = {1'b0, o_code, o_count, o_word};

`ifndef SYNTH
   a_rdv_in_copy: assert property (@(posedge clock) disable iff (reset)
      rdv_ff |-> (st_ff == S_COPY))
      else $error("read pipeline busy outside copy");

   a_flush_drained: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_FLUSH) |-> (issue_left_ff == '0) && !rdv_ff)
      else $error("flush entered with copy pending");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (produced_ff == $past(produced_ff)) ||
                        (produced_ff == $past(produced_ff) + 32'd1) ||
                        (produced_ff == '0))
      else $error("output count jumped");

   a_accept_no_copy: assert property (@(posedge clock) disable iff (reset)
      accept |-> (issue_left_ff == '0))
      else $error("input accepted during copy");
`endif

endmodule
`default_nettype wire
